// File: src/fsd_pkg.sv
// Shared types and constants of the RGB332 error-diffusion dither block.
`default_nettype none

package fsd_pkg;

    // Channel order inside packed words: red lowest, then green, then blue.
    localparam int NCH      = 3;
    localparam int CH_BLUE  = 2;

    // Widths of the per-channel error terms.
    localparam int EW       = 6;   // line-store error, also left-pending error
    localparam int RCW      = 5;   // error carried to the right neighbor
    localparam int BRW      = 2;   // below-right share held for one pixel

    // Configuration register widths, indexes and reset values.
    localparam int CFG_W_BITS = 13;
    localparam int CFG_H_BITS = 16;
    localparam int CFG_D_BITS = 16;
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 16'd480;

    // Quantizer masks.
    localparam logic [7:0] MASK_RED    = 8'hE0;
    localparam logic [7:0] MASK_GREEN  = 8'h1C;
    localparam logic [7:0] REM_MASK_RG = 8'h1F;
    localparam logic [7:0] REM_MASK_B  = 8'h3F;
    localparam logic [7:0] CHAN_MAX    = 8'd255;

    typedef logic [NCH-1:0][7:0]      pix_word_t;
    typedef logic [NCH-1:0][EW-1:0]   err_word_t;
    typedef logic [NCH-1:0][RCW-1:0]  rc_word_t;
    typedef logic [NCH-1:0][BRW-1:0]  br_word_t;

    // Position flags of one pixel in the frame.
    typedef struct packed {
        logic first_row;
        logic col_zero;
        logic last_col;
        logic last_row;
    } ctx_t;

    // Everything the quantizer produces for one pixel.
    typedef struct packed {
        logic [7:0] pixel_index;
        rc_word_t   right_next;
        err_word_t  left_next;
        br_word_t   br_next;
        err_word_t  below_left;
        err_word_t  fresh;
    } diff_t;

endpackage

`default_nettype wire

// File: src/fs_dither_rgb_to_332.sv
// Top level of the RGB888 to RGB332 error-diffusion dither block.
//
//   Channel   Direction  Beat content
//   s_axis    in         tdata = red, green, blue (8 bits each, red lowest)
//   m_axis    out        tdata = pixel_index (RRRGGGBB), tlast = frame_done
//   cfg       in         cfg_index 0 = image_width, 1 = image_height
//
// One pixel per clock sustained while m_ is ready; a pixel passes the p1 and output
// registers. The rate is set by the line store: one read at input time and one write
// per pixel, with the end-of-row second write held in a one-entry buffer.
// Reset (aresetn low at a clock edge) clears counters, carries and handshake
// state; the line store is not cleared, since row 0 reads it as zero and every
// later read hits an entry written in the row before. A stall on m_ holds the
// pixel in flight and stops s_ after one more beat.
`default_nettype none

module fs_dither_rgb_to_332
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input pixels.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // Dithered codes.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // pixel_index [7:0]
    output logic                       m_tlast,   // frame_done
    // Configuration writes.
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_D_BITS-1:0] cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = (AW + 1 > CFG_W_BITS) ? AW + 1 : CFG_W_BITS;

    // Configuration registers.
    logic [CFG_W_BITS-1:0] cfg_width_reg;
    logic [CFG_H_BITS-1:0] cfg_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= WIDTH_RESET;
            cfg_height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_data[CFG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_data[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective last column and last row.
    logic [LW-1:0]         w_eff;
    logic [LW-1:0]         w_last;
    logic [CFG_H_BITS-1:0] h_last;

    always_comb begin
        w_eff = LW'(cfg_width_reg);
        if (w_eff == '0) begin
            w_eff = LW'(1);
        end
        if (w_eff > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end
        w_last = w_eff - LW'(1);
        h_last = (cfg_height_reg == '0) ? '0 : cfg_height_reg - CFG_H_BITS'(1);
    end

    // Handshake control.
    logic p1_valid_reg;
    logic out_valid_reg;
    logic fire;
    logic s_accept;

    assign fire     = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    // Raster position of the next input beat.
    logic [AW-1:0]         acc_col_reg;
    logic [CFG_H_BITS-1:0] acc_row_reg;
    ctx_t                  acc_ctx;

    always_comb begin
        acc_ctx.first_row = (acc_row_reg == '0);
        acc_ctx.col_zero  = (acc_col_reg == '0);
        acc_ctx.last_col  = (LW'(acc_col_reg) >= w_last);
        acc_ctx.last_row  = (acc_row_reg >= h_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_col_reg <= '0;
            acc_row_reg <= '0;
        end else if (s_accept) begin
            if (acc_ctx.last_col) begin
                acc_col_reg <= '0;
                acc_row_reg <= acc_ctx.last_row ? '0 : acc_row_reg + CFG_H_BITS'(1);
            end else begin
                acc_col_reg <= acc_col_reg + AW'(1);
            end
        end
    end

    // Pixel waiting for its line-store read.
    pix_word_t     p1_pix_reg;
    ctx_t          p1_ctx_reg;
    logic [AW-1:0] p1_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (fire) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_pix_reg <= s_tdata;
            p1_ctx_reg <= acc_ctx;
            p1_col_reg <= acc_col_reg;
        end
    end

    // Carries between neighboring pixels.
    rc_word_t  right_reg;
    err_word_t left_reg;
    br_word_t  br_reg;
    diff_t     diff;
    err_word_t mem_rd_data;
    logic      fwd_hit_reg;
    err_word_t fwd_data_reg;
    err_word_t above;

    assign above = fwd_hit_reg ? fwd_data_reg : mem_rd_data;

    fsd_quant u_quant (
        .pix          (p1_pix_reg),
        .above        (above),
        .right_carry  (right_reg),
        .left_pending (left_reg),
        .br_carry     (br_reg),
        .ctx          (p1_ctx_reg),
        .result       (diff)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_reg <= '0;
            left_reg  <= '0;
            br_reg    <= '0;
        end else if (fire) begin
            right_reg <= diff.right_next;
            left_reg  <= diff.left_next;
            br_reg    <= diff.br_next;
        end
    end

    // Line-store writes: the below-left entry, and at row end the entry below.
    logic          p_we;
    logic          s_we;
    logic [AW-1:0] p_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    err_word_t     wr_data;
    logic          wbuf_valid_reg;
    logic [AW-1:0] wbuf_addr_reg;
    err_word_t     wbuf_data_reg;
    logic          wbuf_valid_next;
    logic [AW-1:0] wbuf_addr_next;
    err_word_t     wbuf_data_next;
    logic          wbuf_takes_s;

    assign p_we   = fire && !p1_ctx_reg.last_row && !p1_ctx_reg.col_zero;
    assign s_we   = fire && !p1_ctx_reg.last_row && p1_ctx_reg.last_col;
    assign p_addr = p1_col_reg - AW'(1);

    // The write port serves the below-left entry first, then the buffer, then
    // the row-end entry; whatever is left over waits in the buffer.
    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = p_addr;
        wr_data         = diff.below_left;
        wbuf_valid_next = wbuf_valid_reg;
        wbuf_addr_next  = wbuf_addr_reg;
        wbuf_data_next  = wbuf_data_reg;
        wbuf_takes_s    = 1'b0;
        if (p_we) begin
            wr_en = 1'b1;
            if (s_we) begin
                wbuf_takes_s = 1'b1;
            end
        end else if (wbuf_valid_reg) begin
            wr_en           = 1'b1;
            wr_addr         = wbuf_addr_reg;
            wr_data         = wbuf_data_reg;
            wbuf_valid_next = 1'b0;
            if (s_we) begin
                wbuf_takes_s = 1'b1;
            end
        end else if (s_we) begin
            wr_en   = 1'b1;
            wr_addr = p1_col_reg;
            wr_data = diff.fresh;
        end
        if (wbuf_takes_s) begin
            wbuf_valid_next = 1'b1;
            wbuf_addr_next  = p1_col_reg;
            wbuf_data_next  = diff.fresh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wbuf_valid_reg <= 1'b0;
        end else begin
            wbuf_valid_reg <= wbuf_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wbuf_addr_reg <= wbuf_addr_next;
        wbuf_data_reg <= wbuf_data_next;
    end

    // Forwarding for the read issued with the incoming beat: a fresh buffer
    // entry is newest, then this cycle's write, then an older buffer entry.
    logic      fwd_hit_next;
    err_word_t fwd_data_next;
    logic      hit_buf;
    logic      hit_port;

    always_comb begin
        hit_buf       = wbuf_valid_next && (wbuf_addr_next == acc_col_reg);
        hit_port      = wr_en && (wr_addr == acc_col_reg);
        fwd_hit_next  = hit_buf || hit_port;
        fwd_data_next = wbuf_data_next;
        if (!(wbuf_takes_s && hit_buf) && hit_port) begin
            fwd_data_next = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= fwd_data_next;
        end
    end

    fsd_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_accept),
        .rd_addr (acc_col_reg),
        .rd_data (mem_rd_data)
    );

    // Output register.
    logic [7:0] out_index_reg;
    logic       out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_index_reg <= diff.pixel_index;
            out_last_reg  <= p1_ctx_reg.last_col && p1_ctx_reg.last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_index_reg;
    assign m_tlast  = out_last_reg;

    // The buffer is always empty when a below-left write is due.
    a_wbuf_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !(p_we && wbuf_valid_reg))
        else $error("line-store write buffer busy at a below-left write");

    // A buffered write drains on the next cycle unless a new row-end entry replaces it.
    a_wbuf_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (wbuf_valid_reg && !s_we) |=> !wbuf_valid_reg)
        else $error("line-store write buffer did not drain");

    // After the last pixel of a frame all carries are zero.
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && p1_ctx_reg.last_col && p1_ctx_reg.last_row)
        |=> (right_reg == '0 && left_reg == '0 && br_reg == '0))
        else $error("carries not cleared at frame end");

endmodule

`default_nettype wire

// File: src/fsd_line_mem.sv
// Line store of diffused errors: one write port, one registered read port.
`default_nettype none

module fsd_line_mem
    import fsd_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire err_word_t     wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output err_word_t          rd_data
);

    err_word_t mem [DEPTH];
    err_word_t rd_data_reg;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/fsd_quant.sv
// Per-pixel error add, clamp, RGB332 quantizer and error split.
`default_nettype none

module fsd_quant
    import fsd_pkg::*;
(
    input  wire pix_word_t pix,
    input  wire err_word_t above,
    input  wire rc_word_t  right_carry,
    input  wire err_word_t left_pending,
    input  wire br_word_t  br_carry,
    input  wire ctx_t      ctx,
    output diff_t          result
);

    always_comb begin
        err_word_t       above_eff;
        pix_word_t       vals;
        logic [9:0]      sum;
        logic [7:0]      rem;
        logic [EW-1:0]   e;
        logic [8:0]      p7;
        logic [8:0]      p5;
        logic [8:0]      p3;

        above_eff = ctx.first_row ? '0 : above;
        result    = '0;

        // Channels are independent of each other.
        for (int c = 0; c < NCH; c++) begin
            sum = 10'(pix[c]) + 10'(above_eff[c]) + 10'(right_carry[c]);
            vals[c] = (sum > 10'(CHAN_MAX)) ? CHAN_MAX : sum[7:0];
            rem = (c == CH_BLUE) ? (vals[c] & REM_MASK_B) : (vals[c] & REM_MASK_RG);
            e   = rem[EW-1:0];

            p7 = 9'(e) * 9'd7;
            p5 = 9'(e) * 9'd5;
            p3 = 9'(e) * 9'd3;

            result.fresh[c]      = EW'(p5[8:4]) + EW'(br_carry[c]);
            result.below_left[c] = left_pending[c] + EW'(p3[8:4]);
            result.right_next[c] = ctx.last_col ? '0 : p7[8:4];
            result.left_next[c]  = (ctx.last_row || ctx.last_col) ? '0 : result.fresh[c];
            result.br_next[c]    = (ctx.last_row || ctx.last_col || ctx.col_zero)
                                   ? '0 : e[5:4];
        end

        result.pixel_index = (vals[0] & MASK_RED) | ((vals[1] >> 3) & MASK_GREEN)
                           | (vals[CH_BLUE] >> 6);
    end

endmodule

`default_nettype wire

// File: tb/sv/fs_dither_rgb_to_332_tb.sv
// Self-checking testbench for the RGB888 to RGB332 error-diffusion dither block.
`timescale 1ns / 1ps

module fs_dither_rgb_to_332_tb;
    import fsd_pkg::*;

    localparam int MAX_W          = 4096;
    localparam int IDLE_LIMIT     = 1000;  // cycles without any beat or register write before giving up
    localparam int RANDOM_PIXELS  = 1200;
    localparam int REPORT_CAP     = 100;   // mismatches printed before going quiet

    // One dithered result as the block should produce it.
    typedef struct packed {
        logic [7:0] code;
        logic       frame_end;
    } dither_result_t;

    // Predicts the dithered codes from accepted pixels and checks result beats.
    class dither_scoreboard;
        logic [CFG_W_BITS-1:0] width_reg;
        logic [CFG_H_BITS-1:0] height_reg;
        logic [7:0]            line_err [MAX_W][NCH];
        int unsigned           right_err [NCH];
        int unsigned           left_err [NCH];
        int unsigned           below_right [NCH];
        int unsigned           col_pos;
        int unsigned           row_pos;
        dither_result_t        expected_q [$];
        int unsigned           pixels_seen;
        int unsigned           frames_closed;
        int unsigned           mismatches;

        function new();
            width_reg     = WIDTH_RESET;
            height_reg    = HEIGHT_RESET;
            col_pos       = 0;
            row_pos       = 0;
            pixels_seen   = 0;
            frames_closed = 0;
            mismatches    = 0;
            for (int i = 0; i < MAX_W; i++)
                for (int ch = 0; ch < NCH; ch++)
                    line_err[i][ch] = 8'd0;
            for (int ch = 0; ch < NCH; ch++) begin
                right_err[ch]   = 0;
                left_err[ch]    = 0;
                below_right[ch] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [CFG_D_BITS-1:0] value);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = value[CFG_W_BITS-1:0];
            end else begin
                height_reg = value[CFG_H_BITS-1:0];
            end
        endfunction

        // Quantize one accepted pixel and diffuse its remainder.
        function void note_pixel(pix_word_t px);
            int unsigned    w, h, c, above, fresh, tmp, code_v;
            int unsigned    lvl [NCH];
            int unsigned    rem [NCH];
            bit             last_c, last_r;
            dither_result_t res;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_W) w = MAX_W;
            h = height_reg;
            if (h == 0) h = 1;
            c = col_pos;
            if (c >= MAX_W) c = MAX_W - 1;
            last_c = (c >= w - 1);
            last_r = (row_pos >= h - 1);

            // Add the diffused error, clamp, and keep the truncated remainder.
            for (int ch = 0; ch < NCH; ch++) begin
                above = (row_pos == 0) ? 0 : line_err[c][ch];
                lvl[ch] = px[ch] + above + right_err[ch];
                if (lvl[ch] > CHAN_MAX) lvl[ch] = CHAN_MAX;
                rem[ch] = lvl[ch] & ((ch == CH_BLUE) ? REM_MASK_B : REM_MASK_RG);
            end
            code_v = (lvl[0] & MASK_RED) | ((lvl[1] >> 3) & MASK_GREEN) | (lvl[CH_BLUE] >> 6);
            res.code      = code_v[7:0];
            res.frame_end = last_c && last_r;
            expected_q.push_back(res);

            // Spread the remainder to the right and into the line store.
            for (int ch = 0; ch < NCH; ch++) begin
                right_err[ch] = last_c ? 0 : ((7 * rem[ch]) >> 4);
                if (!last_r) begin
                    fresh = ((5 * rem[ch]) >> 4) + below_right[ch];
                    if (c > 0) begin
                        tmp = left_err[ch] + ((3 * rem[ch]) >> 4);
                        line_err[c - 1][ch] = tmp[7:0];
                    end
                    if (last_c) begin
                        line_err[c][ch] = fresh[7:0];
                        left_err[ch]    = 0;
                        below_right[ch] = 0;
                    end else begin
                        left_err[ch]    = fresh;
                        below_right[ch] = (c > 0) ? (rem[ch] >> 4) : 0;
                    end
                end else begin
                    left_err[ch]    = 0;
                    below_right[ch] = 0;
                end
            end

            // Advance the raster position.
            if (last_c) begin
                col_pos = 0;
                row_pos = last_r ? 0 : row_pos + 1;
            end else begin
                col_pos = c + 1;
            end
            pixels_seen++;
        endfunction

        // Compare one result beat with the oldest prediction.
        function void check_code(logic [7:0] code, logic done);
            dither_result_t exp_res;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $error("unexpected result beat: pixel_index=%0h frame_done=%0b", code, done);
                return;
            end
            exp_res = expected_q.pop_front();
            if (done === 1'b1) frames_closed++;
            if (code !== exp_res.code) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $error("pixel_index: expected %0h, got %0h", exp_res.code, code);
            end
            if (done !== exp_res.frame_end) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $error("frame_done: expected %0b, got %0b", exp_res.frame_end, done);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_D_BITS-1:0] cfg_data;

    dither_scoreboard sb;
    int unsigned      send_gap_max;
    int unsigned      ready_stall_max;
    int unsigned      idle_cycles;
    int unsigned      settings_used;

    fs_dither_rgb_to_332 #(.MAX_WIDTH(MAX_W)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic pix_word_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pix_word_t px;
        px[0]       = r;
        px[1]       = g;
        px[CH_BLUE] = b;
        return px;
    endfunction

    // Channel values lean toward the rails so that clamping is hit often.
    function automatic logic [7:0] random_channel();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic pix_word_t random_pixel();
        return make_pixel(random_channel(), random_channel(), random_channel());
    endfunction

    // Present one pixel after a random gap and wait for its beat.
    task automatic send_pixel(pix_word_t px);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_pixel(px);
    endtask

    // Write the chosen registers back to back, then drop the write enable.
    task automatic program_regs(bit wr_w, logic [CFG_D_BITS-1:0] w_val,
                                bit wr_h, logic [CFG_D_BITS-1:0] h_val);
        if (wr_w) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_IMAGE_WIDTH;
            cfg_data  <= w_val;
            @(posedge aclk);
            sb.set_reg(REG_IMAGE_WIDTH, w_val);
        end
        if (wr_h) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_IMAGE_HEIGHT;
            cfg_data  <= h_val;
            @(posedge aclk);
            sb.set_reg(REG_IMAGE_HEIGHT, h_val);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Stop sending and let every predicted result drain out of the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result side: random stall before each beat, then hold ready until it arrives.
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = $urandom_range(0, ready_stall_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_code(m_tdata, m_tlast);
        end
    end

    // Watchdog on cycles in which no beat and no register write happens.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1) begin
                if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                    idle_cycles = 0;
                end else begin
                    idle_cycles++;
                end
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Watchdog expired after %0d idle cycles.", idle_cycles);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        pix_word_t             directed [$];
        int unsigned           random_sent, phase_len, w_eff, h_eff, pick;
        logic [CFG_W_BITS-1:0] w_sel;
        logic [CFG_H_BITS-1:0] h_sel;
        logic [2:0]            junk;
        bit                    wr_w, wr_h;

        sb              = new();
        settings_used   = 0;
        send_gap_max    = 14;
        ready_stall_max = 14;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pixels: rails, carry buildup into clamping, alternating bits.
        directed = '{make_pixel(8'd0, 8'd0, 8'd0),     make_pixel(8'd255, 8'd255, 8'd255),
                     make_pixel(8'd255, 8'd255, 8'd255), make_pixel(8'h1F, 8'h1F, 8'h3F),
                     make_pixel(8'h1F, 8'h1F, 8'h3F),  make_pixel(8'h1F, 8'h1F, 8'h3F),
                     make_pixel(8'hFF, 8'hFF, 8'hFF),  make_pixel(8'h20, 8'h20, 8'h40),
                     make_pixel(8'hE0, 8'h1C, 8'h03),  make_pixel(8'hAA, 8'h55, 8'hAA),
                     make_pixel(8'h55, 8'hAA, 8'h55),  make_pixel(8'hFF, 8'h00, 8'h00),
                     make_pixel(8'h00, 8'hFF, 8'h00),  make_pixel(8'h00, 8'h00, 8'hFF),
                     make_pixel(8'h01, 8'h01, 8'h01),  make_pixel(8'hFE, 8'hFE, 8'hFE),
                     make_pixel(8'h7F, 8'h80, 8'hFF),  make_pixel(8'h80, 8'h7F, 8'h00),
                     make_pixel(8'hDF, 8'hDF, 8'hBF),  make_pixel(8'h3F, 8'hC0, 8'h7F)};

        // Oversized width acts as the full line; one whole row fills every
        // line-store entry, so later rows never read an unwritten column.
        program_regs(1'b1, 16'hFFFF, 1'b1, 16'd2);
        for (int i = 0; i < MAX_W; i++)
            send_pixel((i < directed.size()) ? directed[i] : random_pixel());
        drain();

        // Zero width and height act as one: the next pixel closes the frame.
        program_regs(1'b1, 16'd0, 1'b1, 16'd0);
        send_pixel(make_pixel(8'd255, 8'd0, 8'd128));
        drain();

        // Random phases: new settings at arbitrary raster positions, mostly small images.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                w_sel = '0;
            end else if (pick == 1) begin
                w_sel = ($urandom_range(0, 1) == 0) ? 13'd4096 : 13'h1FFF;
            end else if (pick == 2) begin
                w_sel = 13'($urandom_range(1, 4096));
            end else begin
                w_sel = 13'($urandom_range(1, 12));
            end
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                h_sel = '0;
            end else if (pick == 1) begin
                h_sel = 16'hFFFF;
            end else begin
                h_sel = 16'($urandom_range(1, 6));
            end
            pick = $urandom_range(0, 3);
            wr_w = (pick != 1);
            wr_h = (pick != 0);
            junk = 3'($urandom_range(0, 7));
            program_regs(wr_w, {junk, w_sel}, wr_h, h_sel);

            send_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 14;
            ready_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;

            w_eff = sb.width_reg;
            if (w_eff == 0) w_eff = 1;
            if (w_eff > MAX_W) w_eff = MAX_W;
            h_eff = (sb.height_reg == 0) ? 1 : sb.height_reg;
            if (w_eff > 64) begin
                phase_len = $urandom_range(1, 150);
            end else begin
                phase_len = $urandom_range(1, (3 * w_eff * h_eff > 200) ? 200
                                                                         : 3 * w_eff * h_eff);
            end
            repeat (phase_len) send_pixel(random_pixel());
            random_sent += phase_len;
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("Run covered %0d pixels under %0d register settings; %0d frames closed.",
                 sb.pixels_seen, settings_used, sb.frames_closed);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results still expected.",
                     sb.mismatches, sb.expected_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
